@@ hdl/element_stream_hash_macros.svh @@
// ---------------------------------------------------------------------------
// element_stream_hash_macros.svh
// Assertion helpers shared by the element stream hash RTL.
// ---------------------------------------------------------------------------
`ifndef ELEMENT_STREAM_HASH_MACROS_SVH
`define ELEMENT_STREAM_HASH_MACROS_SVH

// Same-cycle implication, clocked on aclk, off during reset
`define ESH_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on aclk, off during reset
`define ESH_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/esh_pkg.sv @@
// ---------------------------------------------------------------------------
// esh_pkg
// Types and constants for the element stream hash.
// ---------------------------------------------------------------------------
package esh_pkg;

    localparam int ELEM_W  = 64;
    localparam int HASH_W  = 64;
    localparam int CODE_W  = 2;
    localparam int QUEUE_DEPTH = 4;

    // element width codes
    localparam logic [CODE_W-1:0] CODE_B1 = 2'd0;
    localparam logic [CODE_W-1:0] CODE_B2 = 2'd1;
    localparam logic [CODE_W-1:0] CODE_B4 = 2'd2;
    localparam logic [CODE_W-1:0] CODE_B8 = 2'd3;

    localparam logic [ELEM_W-1:0] ELEM_MUL [4] = '{
        64'd81, 64'd11601, 64'd3432918353, 64'd14744272059406101841
    };
    localparam logic [HASH_W-1:0] HASH_ADD [4] = '{
        64'd237, 64'd12525, 64'd2041000173, 64'd8766028991911375085
    };
    localparam logic [ELEM_W-1:0] WIDTH_MASK [4] = '{
        64'h0000_0000_0000_00FF, 64'h0000_0000_0000_FFFF,
        64'h0000_0000_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF
    };

    // mixed element on its way from front to back
    typedef struct packed {
        logic [ELEM_W-1:0] mixed;
        logic [CODE_W-1:0] code;
        logic              last;
    } entry_t;

    // queue handshake between front and back
    typedef struct packed {
        logic push;
        logic pop;
    } q_ctrl_t;

endpackage

@@ hdl/element_stream_hash.sv @@
// ---------------------------------------------------------------------------
// element_stream_hash
// Hashes a stream of 1/2/4/8-byte elements into a 64-bit value per array.
// ---------------------------------------------------------------------------
// Sustained rate is one element per clock unless the result channel stalls.
// An element is registered, its width-specific multiply runs as three 32x32
// partial products in the next stage, and the rotated result enters a small
// queue (QueueDepth entries). The back end folds one queued element per
// cycle into the running hash; an array's hash reaches m_ through stage 1,
// stage 2, the queue and the output register, later only while earlier
// results are still held up there. Input ready drops only when the queue,
// together with the two front stages, would otherwise overflow, i.e. when
// the result channel stalls. The width code is sampled per element.
`include "element_stream_hash_macros.svh"

module element_stream_hash #(
    parameter int QueueDepth = esh_pkg::QUEUE_DEPTH
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_wr_en,
    input  logic [esh_pkg::CODE_W-1:0] cfg_wr_data,
    input  logic [esh_pkg::ELEM_W-1:0] s_element,
    input  logic                       s_last,
    input  logic                       s_valid,
    output logic                       s_ready,
    output logic [esh_pkg::HASH_W-1:0] m_hash_value,
    output logic                       m_valid,
    input  logic                       m_ready
);

    localparam int CntW = $clog2(QueueDepth + 1);

    logic [esh_pkg::CODE_W-1:0] width_code_reg;
    esh_pkg::q_ctrl_t           q_ctrl;
    logic                       q_push;
    logic                       q_pop;
    esh_pkg::entry_t            push_entry;
    esh_pkg::entry_t            head;
    logic                       not_empty;
    logic [CntW-1:0]            q_count;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_code_reg <= esh_pkg::CODE_B1;
        end else if (cfg_wr_en) begin
            width_code_reg <= cfg_wr_data;
        end
    end

    always_comb begin
        q_ctrl.push = q_push;
        q_ctrl.pop  = q_pop;
    end

    esh_front #(.QueueDepth(QueueDepth)) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_element  (s_element),
        .s_last     (s_last),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .width_code (width_code_reg),
        .q_count    (q_count),
        .push       (q_push),
        .push_entry (push_entry)
    );

    esh_queue #(.QueueDepth(QueueDepth)) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctrl       (q_ctrl),
        .push_entry (push_entry),
        .head       (head),
        .not_empty  (not_empty),
        .count      (q_count)
    );

    esh_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .head         (head),
        .not_empty    (not_empty),
        .pop          (q_pop),
        .m_hash_value (m_hash_value),
        .m_valid      (m_valid),
        .m_ready      (m_ready)
    );

    `ESH_ASSERT_NOW(a_q_bound, 1'b1, q_count <= CntW'(QueueDepth), "queue count over depth")
    `ESH_ASSERT_NOW(a_no_overflow, q_push && !q_pop, q_count < CntW'(QueueDepth), "queue overflow")
    `ESH_ASSERT_NEXT(a_last_out, q_pop && head.last, m_valid, "last element left no result")

endmodule

@@ hdl/esh_front.sv @@
// ---------------------------------------------------------------------------
// esh_front
// Accepts elements, masks them to width and mixes them (multiply, rotate).
// ---------------------------------------------------------------------------
module esh_front #(
    parameter int QueueDepth = esh_pkg::QUEUE_DEPTH,
    localparam int CntW = $clog2(QueueDepth + 1)
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic [esh_pkg::ELEM_W-1:0] s_element,
    input  logic                       s_last,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [esh_pkg::CODE_W-1:0] width_code,
    input  logic [CntW-1:0]            q_count,
    output logic                       push,
    output esh_pkg::entry_t            push_entry
);

    logic                       v1_reg, v1_next;
    logic [esh_pkg::ELEM_W-1:0] el1_reg;
    logic [esh_pkg::CODE_W-1:0] code1_reg;
    logic                       last1_reg;

    logic                       v2_reg, v2_next;
    logic [63:0]                p0_reg;
    logic [31:0]                pc_reg;
    logic [esh_pkg::CODE_W-1:0] code2_reg;
    logic                       last2_reg;

    logic [CntW:0]              pending;
    logic                       accept;
    logic [esh_pkg::ELEM_W-1:0] mul_k;
    logic [31:0]                cross_a, cross_b;
    logic [63:0]                prod;
    logic [63:0]                k;

    // every item in flight already holds a queue slot
    assign pending = (CntW+1)'(q_count) + (CntW+1)'(v1_reg) + (CntW+1)'(v2_reg);
    assign s_ready = pending < (CntW+1)'(QueueDepth);
    assign accept  = s_valid && s_ready;

    assign v1_next = accept;
    assign v2_next = v1_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
        end
    end

    // stage 1: register masked element and the width in force
    always_ff @(posedge aclk) begin
        if (accept) begin
            el1_reg   <= s_element & esh_pkg::WIDTH_MASK[width_code];
            code1_reg <= width_code;
            last1_reg <= s_last;
        end
    end

    // stage 2: 64x64 low product as three 32x32 partials
    assign mul_k   = esh_pkg::ELEM_MUL[code1_reg];
    assign cross_a = el1_reg[31:0] * mul_k[63:32];
    assign cross_b = el1_reg[63:32] * mul_k[31:0];

    always_ff @(posedge aclk) begin
        p0_reg    <= el1_reg[31:0] * mul_k[31:0];
        pc_reg    <= cross_a + cross_b;
        code2_reg <= code1_reg;
        last2_reg <= last1_reg;
    end

    // stage 3: assemble, mask, rotate by half width
    assign prod = p0_reg + {pc_reg, 32'd0};
    assign k    = prod & esh_pkg::WIDTH_MASK[code2_reg];

    always_comb begin
        push_entry.code = code2_reg;
        push_entry.last = last2_reg;
        unique case (code2_reg)
            esh_pkg::CODE_B1: push_entry.mixed = {56'd0, k[3:0], k[7:4]};
            esh_pkg::CODE_B2: push_entry.mixed = {48'd0, k[7:0], k[15:8]};
            esh_pkg::CODE_B4: push_entry.mixed = {32'd0, k[15:0], k[31:16]};
            esh_pkg::CODE_B8: push_entry.mixed = {k[31:0], k[63:32]};
            default:          push_entry.mixed = k;
        endcase
    end

    assign push = v2_reg;

endmodule

@@ hdl/esh_queue.sv @@
// ---------------------------------------------------------------------------
// esh_queue
// Short FIFO of mixed elements between front and back.
// ---------------------------------------------------------------------------
module esh_queue #(
    parameter int QueueDepth = esh_pkg::QUEUE_DEPTH,
    localparam int CntW = $clog2(QueueDepth + 1),
    localparam int PtrW = $clog2(QueueDepth)
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  esh_pkg::q_ctrl_t ctrl,
    input  esh_pkg::entry_t push_entry,
    output esh_pkg::entry_t head,
    output logic            not_empty,
    output logic [CntW-1:0] count
);

    esh_pkg::entry_t store [QueueDepth];

    logic [PtrW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0] count_reg, count_next;

    assign wr_ptr_next = (wr_ptr_reg == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_reg + 1'b1;
    assign rd_ptr_next = (rd_ptr_reg == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_reg + 1'b1;

    always_comb begin
        count_next = count_reg;
        if (ctrl.push && !ctrl.pop) begin
            count_next = count_reg + 1'b1;
        end else if (!ctrl.push && ctrl.pop) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (ctrl.push) wr_ptr_reg <= wr_ptr_next;
            if (ctrl.pop)  rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.push) begin
            store[wr_ptr_reg] <= push_entry;
        end
    end

    assign head      = store[rd_ptr_reg];
    assign not_empty = count_reg != '0;
    assign count     = count_reg;

endmodule

@@ hdl/esh_back.sv @@
// ---------------------------------------------------------------------------
// esh_back
// Folds mixed elements into the running hash and holds the result.
// ---------------------------------------------------------------------------
module esh_back (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  esh_pkg::entry_t            head,
    input  logic                       not_empty,
    output logic                       pop,
    output logic [esh_pkg::HASH_W-1:0] m_hash_value,
    output logic                       m_valid,
    input  logic                       m_ready
);

    logic [esh_pkg::HASH_W-1:0] hash_reg, hash_next;
    logic [esh_pkg::HASH_W-1:0] out_reg;
    logic                       m_valid_reg, m_valid_next;
    logic [esh_pkg::HASH_W-1:0] hx;
    logic                       out_free;

    assign out_free = !m_valid_reg || m_ready;
    // a last entry waits until the output register can take it
    assign pop = not_empty && (!head.last || out_free);

    // (h ^ mix) * 11 + add, modulo 2^64
    assign hx        = hash_reg ^ head.mixed;
    assign hash_next = (hx << 3) + (hx << 1) + hx + esh_pkg::HASH_ADD[head.code];

    always_comb begin
        m_valid_next = m_valid_reg && !m_ready;
        if (pop && head.last) begin
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hash_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            if (pop) begin
                hash_reg <= head.last ? '0 : hash_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop && head.last) begin
            out_reg <= hash_next;
        end
    end

    assign m_hash_value = out_reg;
    assign m_valid      = m_valid_reg;

endmodule
